// ----- sv/tmsrgb_pkg.sv -----
package tmsrgb_pkg;

	// Field widths of the pixel word and the result word.
	localparam int CHAN_W  = 24;
	localparam int COORD_W = 7;
	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = 16;

	localparam int IMAGE_SIZE_DEF = 128;

	// Pipeline shape: one clamp stage, four divider stages, four search stages.
	localparam int DIV_STEPS = 3;
	localparam int NSTG      = 9;

	localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

	// Reinhard divider: t = x / (1 + x) with 12 fractional quotient bits.
	localparam int K_W   = 12;
	localparam int REM_W = 24;
	localparam logic [REM_W-1:0] DEN_ONE = 24'h010000;

	// Codes at or below this use the linear sRGB segment.
	localparam logic [K_W-1:0] K_LIN_LAST = 12'd12;

	// Exact power-curve comparison: (k/4096)^5 >= ((200m + 2705) / 53805)^12.
	localparam int ENC_DEN  = 53805;
	localparam int ENC_MUL  = 200;
	localparam int ENC_OFS  = 2705;
	localparam int BIG_W    = 288;
	localparam int THR_W    = K_W + 1;
	localparam int THR_N    = 256;

	typedef logic [THR_N-1:0][THR_W-1:0] thr_tbl_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [K_W-1:0]   quo;
	} div_st_t;

	// A few restoring division steps; the remainder always stays below den.
	function automatic div_st_t div_steps(input div_st_t st, input logic [REM_W-1:0] den);
		logic [REM_W:0] r2;
		div_st_t        o;
		int             i;
		o = st;
		for (i = 0; i < DIV_STEPS; i++) begin
			r2 = {o.rem, 1'b0};
			if (r2 >= {1'b0, den}) begin
				r2    = r2 - {1'b0, den};
				o.quo = {o.quo[K_W-2:0], 1'b1};
			end else begin
				o.quo = {o.quo[K_W-2:0], 1'b0};
			end
			o.rem = r2[REM_W-1:0];
		end
		return o;
	endfunction

	// Byte of the linear segment: floor((32946 k + 20480) / 40960).
	function automatic logic [BYTE_W-1:0] lin_byte(input logic [3:0] k);
		logic [BYTE_W-1:0] b;
		case (k)
			4'd0:    b = 8'd0;
			4'd1:    b = 8'd1;
			4'd2:    b = 8'd2;
			4'd3:    b = 8'd2;
			4'd4:    b = 8'd3;
			4'd5:    b = 8'd4;
			4'd6:    b = 8'd5;
			4'd7:    b = 8'd6;
			4'd8:    b = 8'd6;
			4'd9:    b = 8'd7;
			4'd10:   b = 8'd8;
			4'd11:   b = 8'd9;
			4'd12:   b = 8'd10;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	// For every byte value m above zero, the smallest code k on the power segment
	// whose encoding reaches m, or 4096 when none does; entry 0 is zero. Evaluated
	// at elaboration with exact wide integers.
	function automatic thr_tbl_t build_thr();
		logic [BIG_W-1:0] a_c;
		logic [BIG_W-1:0] rhs;
		logic [BIG_W-1:0] lhs;
		logic [THR_W-1:0] lo;
		logic [THR_W-1:0] hi;
		logic [THR_W-1:0] mid;
		logic [15:0]      base;
		thr_tbl_t         t;
		int               m;
		int               i;
		int               it;
		a_c = BIG_W'(1);
		for (i = 0; i < 12; i++) begin
			a_c = a_c * BIG_W'(ENC_DEN);
		end
		t    = '0;
		t[0] = '0;
		for (m = 1; m < THR_N; m++) begin
			base = 16'(ENC_MUL * m + ENC_OFS);
			rhs  = BIG_W'(1);
			for (i = 0; i < 12; i++) begin
				rhs = rhs * BIG_W'(base);
			end
			rhs = rhs << (5 * K_W);
			lo  = THR_W'(K_LIN_LAST) + THR_W'(1);
			hi  = THR_W'(1) << K_W;
			for (it = 0; it < THR_W; it++) begin
				if (lo < hi) begin
					mid = (lo + hi) >> 1;
					lhs = BIG_W'(mid);
					for (i = 0; i < 4; i++) begin
						lhs = lhs * BIG_W'(mid);
					end
					lhs = lhs * a_c;
					if (lhs >= rhs) begin
						hi = mid;
					end else begin
						lo = mid + THR_W'(1);
					end
				end
			end
			t[m] = lo;
		end
		return t;
	endfunction

endpackage

// ----- sv/tmsrgb_chan.sv -----
module tmsrgb_chan (
	input  logic                                     clk,
	input  logic [tmsrgb_pkg::NSTG-1:0]              en,
	input  logic signed [tmsrgb_pkg::CHAN_W-1:0]     raw,
	output logic [tmsrgb_pkg::BYTE_W-1:0]            srgb
);
	import tmsrgb_pkg::*;

	localparam thr_tbl_t THR_TBL = build_thr();

	// Two steps of a binary search for the largest m with THR_TBL[m] <= k.
	function automatic logic [BYTE_W-1:0] srch2(input logic [BYTE_W-1:0] lo,
			input logic [K_W-1:0] k, input logic [2:0] b);
		logic [BYTE_W-1:0] res;
		logic [BYTE_W-1:0] cand;
		res  = lo;
		cand = res | (8'd1 << b);
		if (THR_TBL[cand] <= {1'b0, k}) begin
			res = cand;
		end
		cand = res | (8'd1 << (b - 3'd1));
		if (THR_TBL[cand] <= {1'b0, k}) begin
			res = cand;
		end
		return res;
	endfunction

	logic [CHAN_W-2:0]  x_s1;
	logic [REM_W-1:0]   den;
	div_st_t            st0;
	div_st_t            dv_s2, dv_s3, dv_s4, dv_s5;
	logic [REM_W-1:0]   den_s2, den_s3, den_s4;
	logic [K_W-1:0]     k_s6, k_s7, k_s8;
	logic [BYTE_W-1:0]  lo_s6, lo_s7, lo_s8;
	logic [BYTE_W-1:0]  pow_byte;
	logic [BYTE_W-1:0]  byte_s9;

	always_comb begin
		den      = {1'b0, x_s1} + DEN_ONE;
		st0.rem  = {1'b0, x_s1};
		st0.quo  = '0;
		pow_byte = srch2(lo_s8, k_s8, 3'd1);
	end

	always_ff @(posedge clk) begin
		// Negative light clamps to zero.
		if (en[0]) begin
			x_s1 <= raw[CHAN_W-1] ? '0 : raw[CHAN_W-2:0];
		end
		if (en[1]) begin
			dv_s2  <= div_steps(st0, den);
			den_s2 <= den;
		end
		if (en[2]) begin
			dv_s3  <= div_steps(dv_s2, den_s2);
			den_s3 <= den_s2;
		end
		if (en[3]) begin
			dv_s4  <= div_steps(dv_s3, den_s3);
			den_s4 <= den_s3;
		end
		if (en[4]) begin
			dv_s5 <= div_steps(dv_s4, den_s4);
		end
		if (en[5]) begin
			k_s6  <= dv_s5.quo;
			lo_s6 <= srch2(8'd0, dv_s5.quo, 3'd7);
		end
		if (en[6]) begin
			k_s7  <= k_s6;
			lo_s7 <= srch2(lo_s6, k_s6, 3'd5);
		end
		if (en[7]) begin
			k_s8  <= k_s7;
			lo_s8 <= srch2(lo_s7, k_s7, 3'd3);
		end
		if (en[8]) begin
			byte_s9 <= (k_s8 <= K_LIN_LAST) ? lin_byte(k_s8[3:0]) : pow_byte;
		end
	end

	assign srgb = byte_s9;

endmodule

// ----- sv/tonemap_srgb_pixel_store.sv -----
// An accepted word moves through the stages in order to the last, which drives out_valid.
// Throughput: one word per cycle when out_stall is low; nine stages hold one word each.
// Every stage advances on its own when the next one is empty or moving, so bubbles
// close up and up to nine words queue while the output is stalled.
// Reset: arst_n clears the stage valid bits at once; the data registers are not reset.
module tonemap_srgb_pixel_store #(
	parameter int IMAGE_SIZE = tmsrgb_pkg::IMAGE_SIZE_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [tmsrgb_pkg::CHAN_W-1:0]   red_linear,
	input  logic signed [tmsrgb_pkg::CHAN_W-1:0]   green_linear,
	input  logic signed [tmsrgb_pkg::CHAN_W-1:0]   blue_linear,
	input  logic [tmsrgb_pkg::COORD_W-1:0]         pixel_x,
	input  logic [tmsrgb_pkg::COORD_W-1:0]         pixel_y,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [tmsrgb_pkg::BYTE_W-1:0]          red_srgb,
	output logic [tmsrgb_pkg::BYTE_W-1:0]          green_srgb,
	output logic [tmsrgb_pkg::BYTE_W-1:0]          blue_srgb,
	output logic [tmsrgb_pkg::BYTE_W-1:0]          alpha_byte,
	output logic [tmsrgb_pkg::ADDR_W-1:0]          byte_address
);
	import tmsrgb_pkg::*;

	// One valid bit per stage; the last stage is the output register.
	logic [NSTG-1:0]    pipe_vld_q;
	// A stage loads when it is empty or when the stage after it loads.
	logic [NSTG-1:0]    en;
	logic [31:0]        addr_full;
	logic [ADDR_W-1:0]  addr_s [NSTG];
	logic               in_acc;
	logic               out_acc;

	always_comb begin
		en[NSTG-1] = !pipe_vld_q[NSTG-1] || !out_stall;
		for (int i = NSTG - 2; i >= 0; i--) begin
			en[i] = !pipe_vld_q[i] || en[i+1];
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = pipe_vld_q[NSTG-1];
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_vld_q <= '0;
		end else begin
			if (en[0]) begin
				pipe_vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (en[i]) begin
					pipe_vld_q[i] <= pipe_vld_q[i-1];
				end
			end
		end
	end

	// Byte address of the RGBA pixel; it wraps at 64 KiB for large images.
	assign addr_full = (32'(pixel_y) * 32'(IMAGE_SIZE) + 32'(pixel_x)) << 2;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			addr_s[0] <= addr_full[ADDR_W-1:0];
		end
		for (int i = 1; i < NSTG; i++) begin
			if (en[i]) begin
				addr_s[i] <= addr_s[i-1];
			end
		end
	end

	// Each color channel goes through its own clamp, divider and encoder pipeline.
	tmsrgb_chan u_red (
		.clk  (clk),
		.en   (en),
		.raw  (red_linear),
		.srgb (red_srgb)
	);

	tmsrgb_chan u_green (
		.clk  (clk),
		.en   (en),
		.raw  (green_linear),
		.srgb (green_srgb)
	);

	tmsrgb_chan u_blue (
		.clk  (clk),
		.en   (en),
		.raw  (blue_linear),
		.srgb (blue_srgb)
	);

	assign alpha_byte   = ALPHA_OPAQUE;
	assign byte_address = addr_s[NSTG-1];

`ifndef SYNTHESIS
	// The input only stalls once every stage holds a word.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (pipe_vld_q == '1))
		else $error("input stalled with an empty stage");

	// Words in flight change only by what enters and what leaves.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		arst_n |=> $countones(pipe_vld_q) ==
			$past($countones(pipe_vld_q)) + $past(32'(in_acc)) - $past(32'(out_acc)))
		else $error("word lost or duplicated in the pipeline");

	// From an empty pipeline, a word can reach only the first stage by the next cycle.
	a_empty_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pipe_vld_q == '0) |=> (pipe_vld_q[NSTG-1:1] == '0))
		else $error("word skipped a stage");
`endif

endmodule
